FILE: design/speech_rate_quadrilinear_lookup_macros.svh
// assertion macros for the speech rate lookup
`ifndef SPEECH_RATE_QUADRILINEAR_LOOKUP_MACROS_SVH
`define SPEECH_RATE_QUADRILINEAR_LOOKUP_MACROS_SVH
`ifndef SYNTHESIS
`define SRQL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define SRQL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SRQL_ASSERT_IMP(lbl, ante, cons, msg)
`define SRQL_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: design/srql_pkg.sv
// shared constants and types of the speech rate lookup
`timescale 1ns / 1ps
`default_nettype none
package srql_pkg;
  localparam int GRID_POINTS_DEF = 7;
  localparam int ENTRY_BITS_DEF  = 16;
  localparam int ANGLE_STEP      = 480;
  localparam int ANGLE_MAX       = 2880;
  localparam int LEVEL_STEP      = 96;
  localparam int LEVEL_MIN       = 672;
  localparam int LEVEL_MAX       = 1248;
  localparam int LOG_K           = 6313057;
  localparam int DEN_SHIFT       = 20;
  localparam int DEN_ODD         = 2025;
  localparam int DEN_RECIP       = 2120971;
  localparam int QUOT_SHIFT      = 32;
  localparam int GRID_CELLS      = 6;
  localparam int IDX_W           = 3;
  localparam int OFF_W           = 9;
  localparam int LOG_STEPS       = 16;
  localparam int CORNERS         = 16;
  localparam int DRAIN_CYCLES    = 3;
  localparam int CNT_W           = 6;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;
  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_RATE = 1'b1;

  typedef struct packed {
    logic       load;
    logic       wr;
    logic       log_step;
    logic       eff;
    logic       lev;
    logic       brk;
    logic       base;
    logic       corner_en;
    logic [3:0] corner;
    logic       div_init;
    logic       div_step;
    logic       div_fix;
    logic       out_load;
  } srql_cmd_t;

  typedef struct packed {
    logic is_query;
  } srql_stat_t;
endpackage
`default_nettype wire

FILE: design/speech_rate_quadrilinear_lookup.sv
// Speech rate lookup: two ear tables of rate words on a four-axis grid, written
// one entry per item and read back by quadrilinear interpolation. A write item
// passes a write state and then the output state. A query runs the log2 squaring
// loop for the distance term, then steps of level shift, clipping, bracketing and
// base address, 16 corner reads from the single table port, a drain of the
// multiply-accumulate pipe, reciprocal-multiply division with one correction
// step, and an output step that waits while the previous result is still
// stalled. One item is in work at a time; the next is taken while the last
// result still waits in the output register. The table is not cleared by reset.
`timescale 1ns / 1ps
`default_nettype none
`include "speech_rate_quadrilinear_lookup_macros.svh"
module speech_rate_quadrilinear_lookup import srql_pkg::*; #(
  parameter int GRID_POINTS = GRID_POINTS_DEF,
  parameter int ENTRY_BITS  = ENTRY_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               req_type_i,
  input  wire logic               ear_i,
  input  wire logic [2:0]         speaker_index_i,
  input  wire logic [2:0]         listener_index_i,
  input  wire logic [2:0]         pressure_index_i,
  input  wire logic [2:0]         noise_index_i,
  input  wire logic [15:0]        entry_value_i,
  input  wire logic [15:0]        distance_i,
  input  wire logic signed [12:0] speaker_angle_i,
  input  wire logic signed [12:0] listener_angle_i,
  input  wire logic [10:0]        speech_level_i,
  input  wire logic [10:0]        noise_level_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [15:0]             rate_value_o,
  output logic                    result_kind_o
);
  srql_cmd_t  cmd;
  srql_stat_t stat;

  srql_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .req_type_i (req_type_i),
    .cmd_o      (cmd)
  );

  srql_dp #(
    .GRID_POINTS(GRID_POINTS),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .req_type_i      (req_type_i),
    .ear_i           (ear_i),
    .speaker_index_i (speaker_index_i),
    .listener_index_i(listener_index_i),
    .pressure_index_i(pressure_index_i),
    .noise_index_i   (noise_index_i),
    .entry_value_i   (entry_value_i),
    .distance_i      (distance_i),
    .speaker_angle_i (speaker_angle_i),
    .listener_angle_i(listener_angle_i),
    .speech_level_i  (speech_level_i),
    .noise_level_i   (noise_level_i),
    .rate_value_o    (rate_value_o),
    .result_kind_o   (result_kind_o)
  );

  `SRQL_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "item accepted but input not stalled")
  `SRQL_ASSERT_IMP(a_load_on_accept, cmd.load, in_valid_i && !in_stall_o, "datapath load without accepted item")
  `SRQL_ASSERT_NXT(a_result_shown, cmd.out_load, out_valid_o && (result_kind_o == stat.is_query), "result not shown after load")
endmodule
`default_nettype wire

FILE: design/srql_dp.sv
// datapath: log unit, bracketing, table memory, corner accumulate and divider
`timescale 1ns / 1ps
`default_nettype none
module srql_dp import srql_pkg::*; #(
  parameter int GRID_POINTS = GRID_POINTS_DEF,
  parameter int ENTRY_BITS  = ENTRY_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire srql_cmd_t          cmd_i,
  output srql_stat_t              stat_o,
  input  wire logic               req_type_i,
  input  wire logic               ear_i,
  input  wire logic [2:0]         speaker_index_i,
  input  wire logic [2:0]         listener_index_i,
  input  wire logic [2:0]         pressure_index_i,
  input  wire logic [2:0]         noise_index_i,
  input  wire logic [15:0]        entry_value_i,
  input  wire logic [15:0]        distance_i,
  input  wire logic signed [12:0] speaker_angle_i,
  input  wire logic signed [12:0] listener_angle_i,
  input  wire logic [10:0]        speech_level_i,
  input  wire logic [10:0]        noise_level_i,
  output logic [15:0]             rate_value_o,
  output logic                    result_kind_o
);
  localparam int G2    = GRID_POINTS * GRID_POINTS;
  localparam int G3    = G2 * GRID_POINTS;
  localparam int DEPTH = 2 * G3 * GRID_POINTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int ACC_W = ENTRY_BITS + 32;
  localparam int RW    = 27;
  localparam logic signed [23:0] LOG_K_S = 24'(LOG_K);

  function automatic logic [IDX_W+OFF_W-1:0] bracket(input logic [11:0] x,
                                                      input logic [OFF_W-1:0] step);
    logic [IDX_W-1:0] i;
    logic [OFF_W-1:0] f;
    logic [11:0]      prod;
    i    = '0;
    f    = '0;
    prod = '0;
    for (int k = 1; k <= GRID_CELLS; k++) begin
      if (x >= 12'(k) * 12'(step)) i = i + IDX_W'(1);
    end
    if (int'(i) >= GRID_POINTS - 1) begin
      i = IDX_W'(GRID_POINTS - 2);
      f = step;
    end else begin
      prod = 12'(i) * 12'(step);
      f    = OFF_W'(x - prod);
    end
    return {i, f};
  endfunction

  // captured item
  logic                req_q, ear_q;
  logic [2:0]          spk_q, lis_q, prs_q, noi_q;
  logic [15:0]         entry_q;
  logic signed [12:0]  sa_q, la_q;
  logic [10:0]         speech_q, noise_q;

  // log unit
  logic [15:0] dist0, m_d;
  logic [3:0]  n_d, n_q;
  logic [15:0] m_q, frac_q;
  logic [31:0] sq;
  logic [16:0] sh;
  logic signed [20:0] diff;
  logic signed [44:0] t_q, rnd;
  logic signed [12:0] eff;
  logic signed [13:0] sp_sum;
  logic [10:0]        sp_clip, no_clip;
  logic [12:0]        sa_abs, la_abs;

  logic [11:0]          x_q [4];
  logic [IDX_W-1:0]     idx_q [4];
  logic [OFF_W-1:0]     off_q [4];
  logic [OFF_W-1:0]     step_c [4];
  logic [IDX_W+OFF_W-1:0] br [4];
  logic [AW-1:0]        base_q, raddr, waddr;
  logic                 wr_ok;

  // accumulate pipe
  logic [OFF_W-1:0]      w [4];
  logic [17:0]           wa_q;
  logic [13:0]           wl_q;
  logic [31:0]           w_q;
  logic [ENTRY_BITS-1:0] rd_q, rd2_q;
  logic [ACC_W-1:0]      prod_q, acc_q, acc_rnd;
  logic                  v1_q, v2_q, v3_q;

  logic [ENTRY_BITS-1:0] mem [DEPTH];

  // divider: reciprocal multiply, then one correction step
  logic [RW-1:0] rem_q;
  logic [47:0]   qprod;
  logic [27:0]   qback, rfix;
  logic [15:0]   quot_q;
  logic          ge;

  logic [15:0] rate_q;
  logic        kind_q;

  always_comb begin
    dist0 = (distance_i == 16'd0) ? 16'd1 : distance_i;
    n_d   = '0;
    for (int k = 1; k < 16; k++) begin
      if (dist0[k]) n_d = 4'(k);
    end
    m_d = dist0 << (4'd15 - n_d);
  end

  assign sq     = 32'(m_q) * 32'(m_q);
  assign sh     = sq[31:15];
  assign diff   = $signed({1'b0, 20'(8 << 16)}) - $signed({1'b0, n_q, frac_q});
  assign rnd    = t_q + 45'sd2147483648;
  assign eff    = rnd[44:32];
  assign sp_sum = $signed({3'b000, speech_q}) + $signed({eff[12], eff});
  assign sa_abs = sa_q[12] ? 13'(-sa_q) : 13'(sa_q);
  assign la_abs = la_q[12] ? 13'(-la_q) : 13'(la_q);

  always_comb begin
    if (sp_sum < 14'(LEVEL_MIN)) sp_clip = 11'(LEVEL_MIN);
    else if (sp_sum > 14'(LEVEL_MAX)) sp_clip = 11'(LEVEL_MAX);
    else sp_clip = 11'(sp_sum);
    if (noise_q < 11'(LEVEL_MIN)) no_clip = 11'(LEVEL_MIN);
    else if (noise_q > 11'(LEVEL_MAX)) no_clip = 11'(LEVEL_MAX);
    else no_clip = noise_q;
  end

  assign step_c[0] = OFF_W'(ANGLE_STEP);
  assign step_c[1] = OFF_W'(ANGLE_STEP);
  assign step_c[2] = OFF_W'(LEVEL_STEP);
  assign step_c[3] = OFF_W'(LEVEL_STEP);

  always_comb begin
    for (int a = 0; a < 4; a++) begin
      br[a] = bracket(x_q[a], step_c[a]);
      w[a]  = cmd_i.corner[3 - a] ? off_q[a] : OFF_W'(step_c[a] - off_q[a]);
    end
  end

  assign raddr = base_q + AW'(int'(cmd_i.corner[3]) * G3 + int'(cmd_i.corner[2]) * G2
                 + int'(cmd_i.corner[1]) * GRID_POINTS + int'(cmd_i.corner[0]));
  assign waddr = AW'((((int'(ear_q) * GRID_POINTS + int'(spk_q)) * GRID_POINTS
                 + int'(lis_q)) * GRID_POINTS + int'(prs_q)) * GRID_POINTS + int'(noi_q));
  assign wr_ok = (int'(spk_q) < GRID_POINTS) && (int'(lis_q) < GRID_POINTS)
              && (int'(prs_q) < GRID_POINTS) && (int'(noi_q) < GRID_POINTS);
  assign acc_rnd = acc_q + ACC_W'(DEN_ODD * (1 << (DEN_SHIFT - 1)));
  assign qprod   = 48'(rem_q) * 48'(DEN_RECIP);
  assign qback   = 28'(quot_q) * 28'(DEN_ODD);
  assign rfix    = 28'(rem_q) - qback;
  assign ge      = rfix >= 28'(DEN_ODD);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && wr_ok) begin
      mem[waddr] <= ENTRY_BITS'(entry_q);
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q    <= req_type_i;
      ear_q    <= ear_i;
      spk_q    <= speaker_index_i;
      lis_q    <= listener_index_i;
      prs_q    <= pressure_index_i;
      noi_q    <= noise_index_i;
      entry_q  <= entry_value_i;
      sa_q     <= speaker_angle_i;
      la_q     <= listener_angle_i;
      speech_q <= speech_level_i;
      noise_q  <= noise_level_i;
      n_q      <= n_d;
      m_q      <= m_d;
      frac_q   <= '0;
    end
    if (cmd_i.log_step) begin
      m_q    <= sh[16] ? sh[16:1] : sh[15:0];
      frac_q <= {frac_q[14:0], sh[16]};
    end
    if (cmd_i.eff) begin
      t_q <= 45'(LOG_K_S) * 45'(diff);
    end
    if (cmd_i.lev) begin
      x_q[0] <= (sa_abs > 13'(ANGLE_MAX)) ? 12'(ANGLE_MAX) : 12'(sa_abs);
      x_q[1] <= (la_abs > 13'(ANGLE_MAX)) ? 12'(ANGLE_MAX) : 12'(la_abs);
      x_q[2] <= 12'(sp_clip - 11'(LEVEL_MIN));
      x_q[3] <= 12'(no_clip - 11'(LEVEL_MIN));
    end
    if (cmd_i.brk) begin
      for (int a = 0; a < 4; a++) begin
        idx_q[a] <= br[a][IDX_W+OFF_W-1:OFF_W];
        off_q[a] <= br[a][OFF_W-1:0];
      end
    end
    if (cmd_i.base) begin
      base_q <= AW'((((int'(ear_q) * GRID_POINTS + int'(idx_q[0])) * GRID_POINTS
                + int'(idx_q[1])) * GRID_POINTS + int'(idx_q[2])) * GRID_POINTS
                + int'(idx_q[3]));
    end
    wa_q   <= 18'(w[0]) * 18'(w[1]);
    wl_q   <= 14'(w[2][6:0]) * 14'(w[3][6:0]);
    w_q    <= 32'(wa_q) * 32'(wl_q);
    rd2_q  <= rd_q;
    prod_q <= ACC_W'(w_q) * ACC_W'(rd2_q);
    if (cmd_i.div_init) begin
      rem_q  <= RW'(acc_rnd >> DEN_SHIFT);
      quot_q <= '0;
    end else if (cmd_i.div_step) begin
      quot_q <= qprod[QUOT_SHIFT+15:QUOT_SHIFT];
    end else if (cmd_i.div_fix && ge) begin
      quot_q <= quot_q + 16'd1;
    end
    if (cmd_i.out_load) begin
      rate_q <= req_q ? quot_q : 16'd0;
      kind_q <= req_q ? KIND_RATE : KIND_ACK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      v1_q <= cmd_i.corner_en;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (cmd_i.base) acc_q <= '0;
      else if (v3_q) acc_q <= acc_q + prod_q;
    end
  end

  assign stat_o.is_query = (req_q == REQ_QUERY);
  assign rate_value_o    = rate_q;
  assign result_kind_o   = kind_q;
endmodule
`default_nettype wire

FILE: design/srql_ctrl.sv
// controller state machine sequencing the datapath
`timescale 1ns / 1ps
`default_nettype none
module srql_ctrl import srql_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  input  wire logic       req_type_i,
  output srql_cmd_t       cmd_o
);
  typedef enum logic [3:0] {
    IDLE, WRITE, LOG, EFF, LEV, BRK, BASE, ACC, DRAIN, DINIT, DIVS, DFIX, DONE
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             accept, out_free;

  assign accept   = in_valid_i && (state_q == IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.corner = cnt_q[3:0];
    case (state_q)
      IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = (req_type_i == REQ_QUERY) ? LOG : WRITE;
        end
      end
      WRITE: begin
        cmd_o.wr = 1'b1;
        state_d  = DONE;
      end
      LOG: begin
        cmd_o.log_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(LOG_STEPS - 1)) begin
          state_d = EFF;
        end
      end
      EFF: begin
        cmd_o.eff = 1'b1;
        state_d   = LEV;
      end
      LEV: begin
        cmd_o.lev = 1'b1;
        state_d   = BRK;
      end
      BRK: begin
        cmd_o.brk = 1'b1;
        state_d   = BASE;
      end
      BASE: begin
        cmd_o.base = 1'b1;
        cnt_d      = '0;
        state_d    = ACC;
      end
      ACC: begin
        cmd_o.corner_en = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(CORNERS - 1)) begin
          cnt_d   = '0;
          state_d = DRAIN;
        end
      end
      DRAIN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DRAIN_CYCLES - 1)) begin
          state_d = DINIT;
        end
      end
      DINIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = DIVS;
      end
      DIVS: begin
        cmd_o.div_step = 1'b1;
        state_d        = DFIX;
      end
      DFIX: begin
        cmd_o.div_fix = 1'b1;
        state_d       = DONE;
      end
      DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = IDLE;
        end
      end
      default: begin
        state_d = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != IDLE);
  assign out_valid_o = out_valid_q;
endmodule
`default_nettype wire

FILE: tb/speech_rate_quadrilinear_lookup_checker.sv
// checker: predicts each result of the speech rate lookup and compares it
`timescale 1ns / 1ps
module speech_rate_quadrilinear_lookup_checker import srql_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire logic               req_type_i,
  input  wire logic               ear_i,
  input  wire logic [2:0]         speaker_index_i,
  input  wire logic [2:0]         listener_index_i,
  input  wire logic [2:0]         pressure_index_i,
  input  wire logic [2:0]         noise_index_i,
  input  wire logic [15:0]        entry_value_i,
  input  wire logic [15:0]        distance_i,
  input  wire logic signed [12:0] speaker_angle_i,
  input  wire logic signed [12:0] listener_angle_i,
  input  wire logic [10:0]        speech_level_i,
  input  wire logic [10:0]        noise_level_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire logic [15:0]        rate_value_i,
  input  wire logic               result_kind_i,
  output int                      fail_count_o,
  output int                      pending_o
);
  localparam int NPTS = GRID_POINTS_DEF;

  typedef struct packed {
    logic [15:0] rate;
    logic        kind;
  } rate_result_t;

  logic [15:0]  rate_table [2*NPTS*NPTS*NPTS*NPTS];
  rate_result_t expected_rates[$];

  function automatic longint unsigned log2_q16(longint unsigned v);
    longint unsigned n, frac, m;
    n = 0;
    frac = 0;
    while (n < 15 && (v >> (n + 1)) != 0) n++;
    m = (v << (15 - n)) & 64'hFFFF;
    for (int k = 0; k < LOG_STEPS; k++) begin
      m = (m * m) >> 15;
      frac = frac << 1;
      if (m >= 65536) begin
        frac |= 1;
        m = m >> 1;
      end
    end
    return (n << 16) | frac;
  endfunction

  function automatic longint clamp(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic logic [15:0] interpolate_rate(
      logic ear, logic [15:0] dist_in, logic signed [12:0] sa_raw,
      logic signed [12:0] la_raw, logic [10:0] spl, logic [10:0] nl);
    longint t, eff, x[4], st[4];
    longint unsigned idx[4], off[4], sum, w, a, den, d;
    d = (dist_in == 0) ? 1 : dist_in;
    t = longint'(LOG_K) * ((longint'(8) << 16) - longint'(log2_q16(d)));
    eff = (t + (longint'(1) << 31)) >>> 32;
    x[0] = clamp(sa_raw < 0 ? -longint'(sa_raw) : longint'(sa_raw), 0, ANGLE_MAX);
    x[1] = clamp(la_raw < 0 ? -longint'(la_raw) : longint'(la_raw), 0, ANGLE_MAX);
    x[2] = clamp(longint'(spl) + eff, LEVEL_MIN, LEVEL_MAX) - LEVEL_MIN;
    x[3] = clamp(longint'(nl), LEVEL_MIN, LEVEL_MAX) - LEVEL_MIN;
    st[0] = ANGLE_STEP;
    st[1] = ANGLE_STEP;
    st[2] = LEVEL_STEP;
    st[3] = LEVEL_STEP;
    for (int ax = 0; ax < 4; ax++) begin
      idx[ax] = x[ax] / st[ax];
      off[ax] = x[ax] % st[ax];
      if (idx[ax] >= NPTS - 1) begin
        idx[ax] = NPTS - 2;
        off[ax] = st[ax];
      end
    end
    sum = 0;
    for (int c = 0; c < CORNERS; c++) begin
      w = 1;
      a = ear;
      for (int ax = 0; ax < 4; ax++) begin
        a = a * NPTS + idx[ax] + ((c >> (3 - ax)) & 1);
        w = w * (((c >> (3 - ax)) & 1) ? off[ax] : (st[ax] - off[ax]));
      end
      sum += w * rate_table[a];
    end
    den = longint'(ANGLE_STEP) * ANGLE_STEP * LEVEL_STEP * LEVEL_STEP;
    return 16'((sum + den / 2) / den);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rate_result_t exp_r;
    int addr;
    if (!rst_ni) begin
      fail_count_o <= 0;
      pending_o <= 0;
      expected_rates.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_rates.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result rate=%0d kind=%0d",
                                          rate_value_i, result_kind_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_rates.pop_front();
          if (exp_r.rate !== rate_value_i || exp_r.kind !== result_kind_i) begin
            if (fail_count_o < 10)
              $display("result differs: expected rate=%0d kind=%0d, got rate=%0d kind=%0d",
                       exp_r.rate, exp_r.kind, rate_value_i, result_kind_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (req_type_i == REQ_WRITE) begin
          if (speaker_index_i < NPTS && listener_index_i < NPTS &&
              pressure_index_i < NPTS && noise_index_i < NPTS) begin
            addr = (((int'(ear_i) * NPTS + speaker_index_i) * NPTS + listener_index_i)
                    * NPTS + pressure_index_i) * NPTS + noise_index_i;
            rate_table[addr] = entry_value_i;
          end
          exp_r.rate = '0;
          exp_r.kind = KIND_ACK;
        end else begin
          exp_r.rate = interpolate_rate(ear_i, distance_i, speaker_angle_i, listener_angle_i,
                                        speech_level_i, noise_level_i);
          exp_r.kind = KIND_RATE;
        end
        expected_rates.push_back(exp_r);
      end
      pending_o <= expected_rates.size();
    end
  end
endmodule

FILE: tb/tb_speech_rate_quadrilinear_lookup.sv
// testbench top: drives the speech rate lookup and reports the verdict
`timescale 1ns / 1ps
module tb_speech_rate_quadrilinear_lookup import srql_pkg::*;;
  localparam int NPTS        = GRID_POINTS_DEF;
  localparam int CYCLE_LIMIT = 2000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               req_type = REQ_WRITE;
  logic               ear = 1'b0;
  logic [2:0]         speaker_index = '0;
  logic [2:0]         listener_index = '0;
  logic [2:0]         pressure_index = '0;
  logic [2:0]         noise_index = '0;
  logic [15:0]        entry_value = '0;
  logic [15:0]        distance = 16'd256;
  logic signed [12:0] speaker_angle = '0;
  logic signed [12:0] listener_angle = '0;
  logic [10:0]        talk_level = '0;
  logic [10:0]        noise_level = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [15:0]        rate_value;
  logic               result_kind;
  int                 fail_count;
  int                 pending;
  int                 cycle_count = 0;
  int                 stall_left = 0;
  bit                 quiet = 1'b0;

  speech_rate_quadrilinear_lookup dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .req_type_i(req_type), .ear_i(ear),
    .speaker_index_i(speaker_index), .listener_index_i(listener_index),
    .pressure_index_i(pressure_index), .noise_index_i(noise_index),
    .entry_value_i(entry_value), .distance_i(distance),
    .speaker_angle_i(speaker_angle), .listener_angle_i(listener_angle),
    .speech_level_i(talk_level), .noise_level_i(noise_level),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .rate_value_o(rate_value), .result_kind_o(result_kind)
  );

  speech_rate_quadrilinear_lookup_checker rate_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .req_type_i(req_type), .ear_i(ear),
    .speaker_index_i(speaker_index), .listener_index_i(listener_index),
    .pressure_index_i(pressure_index), .noise_index_i(noise_index),
    .entry_value_i(entry_value), .distance_i(distance),
    .speaker_angle_i(speaker_angle), .listener_angle_i(listener_angle),
    .speech_level_i(talk_level), .noise_level_i(noise_level),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .rate_value_i(rate_value), .result_kind_i(result_kind),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("speech_rate_quadrilinear_lookup: mismatch");
      $finish;
    end
  end

  // result side back-pressure: a random hold-off after each accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    int w;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      w = quiet ? 0 : $urandom_range(0, 7);
      stall_left <= w;
      out_stall <= (w != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end
  end

  task automatic send_item(logic rt, logic e, logic [2:0] si, logic [2:0] li, logic [2:0] pi,
                           logic [2:0] ni, logic [15:0] val, logic [15:0] dist_w,
                           logic [12:0] sa, logic [12:0] la, logic [10:0] spl,
                           logic [10:0] nl);
    int gap;
    logic st;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    ear <= e;
    speaker_index <= si;
    listener_index <= li;
    pressure_index <= pi;
    noise_index <= ni;
    entry_value <= val;
    distance <= dist_w;
    speaker_angle <= sa;
    listener_angle <= la;
    talk_level <= spl;
    noise_level <= nl;
    do begin
      @(negedge clk_i);
      st = in_stall;
      @(posedge clk_i);
    end while (st);
  endtask

  task automatic send_write(logic e, logic [2:0] si, logic [2:0] li, logic [2:0] pi,
                            logic [2:0] ni, logic [15:0] val);
    send_item(REQ_WRITE, e, si, li, pi, ni, val, 16'($urandom), 13'($urandom),
              13'($urandom), 11'($urandom), 11'($urandom));
  endtask

  task automatic send_query(logic [15:0] dist_w, logic [12:0] sa, logic [12:0] la,
                            logic [10:0] spl, logic [10:0] nl);
    send_item(REQ_QUERY, 1'($urandom), 3'($urandom), 3'($urandom), 3'($urandom),
              3'($urandom), 16'($urandom), dist_w, sa, la, spl, nl);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [12:0] pick_angle();
    if ($urandom_range(0, 3) == 0) return 13'($urandom);
    return 13'($signed($urandom_range(0, 5760)) - 2880);
  endfunction

  function automatic logic [10:0] pick_level();
    if ($urandom_range(0, 2) == 0) return 11'($urandom);
    return 11'($urandom_range(600, 1320));
  endfunction

  function automatic logic [15:0] pick_distance();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 3));
      1: return 16'($urandom);
      default: return 16'($urandom_range(32, 4096));
    endcase
  endfunction

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every entry of both tables is written before any query
    for (int e = 0; e < 2; e++)
      for (int s = 0; s < NPTS; s++)
        for (int l = 0; l < NPTS; l++)
          for (int p = 0; p < NPTS; p++)
            for (int n = 0; n < NPTS; n++) begin
              if ((s + l + p + n) % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
              send_write(1'(e), 3'(s), 3'(l), 3'(p), 3'(n), pick_value());
            end

    // directed corners
    quiet = 1'b0;
    send_write(1'b0, 3'd7, 3'd0, 3'd0, 3'd0, 16'hFFFF);
    send_write(1'b1, 3'd0, 3'd7, 3'd7, 3'd7, 16'h1234);
    send_write(1'b1, 3'd6, 3'd6, 3'd6, 3'd6, 16'hFFFF);
    send_write(1'b0, 3'd0, 3'd0, 3'd0, 3'd0, 16'h0000);
    send_query(16'd0, 13'sd0, 13'sd0, 11'd0, 11'd0);
    send_query(16'd1, -13'sd2880, 13'sd2880, 11'd2047, 11'd2047);
    send_query(16'd65535, 13'h1000, 13'h0FFF, 11'd672, 11'd1248);
    send_query(16'd256, 13'sd2880, -13'sd2880, 11'd1248, 11'd672);
    send_query(16'd256, 13'sd479, 13'sd481, 11'd1000, 11'd1000);
    send_query(16'd512, -13'sd1, 13'sd1, 11'd767, 11'd768);
    send_query(16'd128, 13'sd2400, 13'sd2399, 11'd1152, 11'd1151);
    send_query(16'hFFFF, 13'h1FFF, 13'h1555, 11'h555, 11'h2AA);
    send_query(16'h5555, 13'h0AAA, 13'h1000, 11'h7FF, 11'h400);
    send_query(16'hAAAA, 13'sd3000, -13'sd3000, 11'd1300, 11'd600);

    for (int i = 0; i < 1600; i++) begin
      if (i % 150 == 0) quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 35)
        send_write(1'($urandom), 3'($urandom_range(0, 6)), 3'($urandom_range(0, 6)),
                   ($urandom_range(0, 9) == 0) ? 3'd7 : 3'($urandom_range(0, 6)),
                   3'($urandom_range(0, 6)), pick_value());
      else
        send_query(pick_distance(), pick_angle(), pick_angle(), pick_level(), pick_level());
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("speech_rate_quadrilinear_lookup: match");
    end else begin
      $display("speech_rate_quadrilinear_lookup: mismatch");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+design
design/srql_pkg.sv
design/srql_dp.sv
design/srql_ctrl.sv
design/speech_rate_quadrilinear_lookup.sv
tb/speech_rate_quadrilinear_lookup_checker.sv
tb/tb_speech_rate_quadrilinear_lookup.sv
